/* hw/rtl/ddsc_pkg.sv */
// Package with the shared constants and types of the dominant direction side coder.
package ddsc_pkg;

	localparam int LANES = 8;
	localparam int DIR_W = 3;
	localparam int CNT_W = 4;
	localparam int DEF_MAX_DIRECTIONS = 8;
	localparam int DEF_RESPONSE_WIDTH = 32;
	localparam logic [CNT_W-1:0] NUM_DIR_RESET = CNT_W'(6);
	localparam logic [CNT_W-1:0] MIN_DIRECTIONS = CNT_W'(2);

	typedef struct packed {
		logic [DIR_W-1:0] dir;
		logic             side;
		logic             last;
	} scale_ctl_t;

endpackage

/* hw/rtl/ddsc_if.sv */
// Handshake interfaces for the scale input channel and the code output channel.
interface ddsc_scale_if #(
	parameter int RESPONSE_WIDTH = ddsc_pkg::DEF_RESPONSE_WIDTH
);
	logic                             valid;
	logic                             ready;
	logic signed [RESPONSE_WIDTH-1:0] response_0;
	logic signed [RESPONSE_WIDTH-1:0] response_1;
	logic signed [RESPONSE_WIDTH-1:0] response_2;
	logic signed [RESPONSE_WIDTH-1:0] response_3;
	logic signed [RESPONSE_WIDTH-1:0] response_4;
	logic signed [RESPONSE_WIDTH-1:0] response_5;
	logic signed [RESPONSE_WIDTH-1:0] response_6;
	logic signed [RESPONSE_WIDTH-1:0] response_7;
	logic                             last_scale;

	modport source (
		output valid, response_0, response_1, response_2, response_3,
		       response_4, response_5, response_6, response_7, last_scale,
		input  ready
	);
	modport sink (
		input  valid, response_0, response_1, response_2, response_3,
		       response_4, response_5, response_6, response_7, last_scale,
		output ready
	);
endinterface

interface ddsc_code_if #(
	parameter int RESPONSE_WIDTH = ddsc_pkg::DEF_RESPONSE_WIDTH
);
	logic                             valid;
	logic                             ready;
	logic signed [RESPONSE_WIDTH-1:0] max_response;
	logic [ddsc_pkg::DIR_W-1:0]       dominant_direction;
	logic                             side_bit;

	modport source (
		output valid, max_response, dominant_direction, side_bit,
		input  ready
	);
	modport sink (
		input  valid, max_response, dominant_direction, side_bit,
		output ready
	);
endinterface

/* hw/rtl/dominant_direction_side_coder.sv */
// The dominant direction side coder takes one transaction per cycle while its input is not
// held off, each holding the responses of all direction lanes for one scale of a pixel, and
// keeps the strongest scale. Eight lane comparators and a merging stage find the scale's
// winner in the cycle in which the transaction is accepted, and the stage register captures
// it at that edge. From the stage register the winner is folded into the running best, and
// a transaction marked as the last scale loads the code into the output register at that
// same edge. Throughput is one transaction per cycle while no earlier code is left untaken.
// A last-scale transaction waits in the stage register while an earlier code in the output
// register has not been taken, and the input is held off until it moves on. The code is
// offered from the output register once its last-scale transaction has left the stage register.
module dominant_direction_side_coder #(
	parameter int MAX_DIRECTIONS = ddsc_pkg::DEF_MAX_DIRECTIONS,
	parameter int RESPONSE_WIDTH = ddsc_pkg::DEF_RESPONSE_WIDTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [ddsc_pkg::CNT_W-1:0] cfg_wr_data,
	ddsc_scale_if.sink                 scale,
	ddsc_code_if.source                code
);
	import ddsc_pkg::*;

	localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_DIRECTIONS);

	logic [CNT_W-1:0]                 num_dir_q;
	logic [CNT_W-1:0]                 active;
	logic signed [RESPONSE_WIDTH-1:0] resp [LANES];
	logic [LANES-1:0]                 win;
	logic [LANES-1:0]                 side;
	logic signed [RESPONSE_WIDTH-1:0] top;
	scale_ctl_t                       ctl;

	logic                             valid_s1;
	logic signed [RESPONSE_WIDTH-1:0] top_s1;
	scale_ctl_t                       ctl_s1;
	logic                             go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_dir_q <= NUM_DIR_RESET;
		end else if (cfg_wr_en) begin
			num_dir_q <= cfg_wr_data;
		end
	end

	always_comb begin
		if (num_dir_q < MIN_DIRECTIONS) begin
			active = MIN_DIRECTIONS;
		end else if (num_dir_q > CAP) begin
			active = CAP;
		end else begin
			active = num_dir_q;
		end
	end

	assign resp[0] = scale.response_0;
	assign resp[1] = scale.response_1;
	assign resp[2] = scale.response_2;
	assign resp[3] = scale.response_3;
	assign resp[4] = scale.response_4;
	assign resp[5] = scale.response_5;
	assign resp[6] = scale.response_6;
	assign resp[7] = scale.response_7;

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		ddsc_lane #(
			.RESPONSE_WIDTH(RESPONSE_WIDTH),
			.LANE          (g)
		) u_lane (
			.resp  (resp),
			.active(active),
			.win   (win[g]),
			.side  (side[g])
		);
	end

	ddsc_merge #(
		.RESPONSE_WIDTH(RESPONSE_WIDTH)
	) u_merge (
		.resp(resp),
		.win (win),
		.side(side),
		.last(scale.last_scale),
		.top (top),
		.ctl (ctl)
	);

	assign scale.ready = !valid_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (scale.ready) begin
			valid_s1 <= scale.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (scale.valid && scale.ready) begin
			top_s1 <= top;
			ctl_s1 <= ctl;
		end
	end

	ddsc_accum #(
		.RESPONSE_WIDTH(RESPONSE_WIDTH)
	) u_accum (
		.clk   (clk),
		.arst_n(arst_n),
		.valid (valid_s1),
		.top   (top_s1),
		.ctl   (ctl_s1),
		.go    (go_s1),
		.code  (code)
	);

endmodule

/* hw/rtl/ddsc_lane.sv */
// One direction lane: decides whether this direction wins the scale and forms its side bit.
module ddsc_lane #(
	parameter int RESPONSE_WIDTH = ddsc_pkg::DEF_RESPONSE_WIDTH,
	parameter int LANE = 0
) (
	input  logic signed [RESPONSE_WIDTH-1:0] resp [ddsc_pkg::LANES],
	input  logic [ddsc_pkg::CNT_W-1:0]       active,
	output logic                             win,
	output logic                             side
);
	import ddsc_pkg::*;

	localparam logic [CNT_W-1:0] LANE_C    = CNT_W'(LANE);
	localparam logic [DIR_W-1:0] NEXT_FIX  = DIR_W'((LANE + 1) % LANES);
	localparam logic [DIR_W-1:0] PREV_FIX  = DIR_W'((LANE + LANES - 1) % LANES);

	logic [CNT_W-1:0] last_idx;
	logic [DIR_W-1:0] nxt_idx;
	logic [DIR_W-1:0] prv_idx;

	// A lane wins when it beats every lower lane strictly and ties or beats every higher active lane.
	always_comb begin
		win = (LANE_C < active);
		for (int j = 0; j < LANES; j++) begin
			if (j < LANE) begin
				win = win & (resp[LANE] > resp[j]);
			end else if ((j > LANE) && (CNT_W'(j) < active)) begin
				win = win & (resp[LANE] >= resp[j]);
			end
		end
	end

	always_comb begin
		last_idx = active - CNT_W'(1);
		nxt_idx  = (LANE_C == last_idx) ? DIR_W'(0) : NEXT_FIX;
		prv_idx  = (LANE == 0) ? last_idx[DIR_W-1:0] : PREV_FIX;
		side     = (resp[nxt_idx] >= resp[prv_idx]);
	end

endmodule

/* hw/rtl/ddsc_merge.sv */
// Merging stage: turns the one-hot lane decisions into the scale's maximum, direction and side bit.
module ddsc_merge #(
	parameter int RESPONSE_WIDTH = ddsc_pkg::DEF_RESPONSE_WIDTH
) (
	input  logic signed [RESPONSE_WIDTH-1:0] resp [ddsc_pkg::LANES],
	input  logic [ddsc_pkg::LANES-1:0]       win,
	input  logic [ddsc_pkg::LANES-1:0]       side,
	input  logic                             last,
	output logic signed [RESPONSE_WIDTH-1:0] top,
	output ddsc_pkg::scale_ctl_t             ctl
);
	import ddsc_pkg::*;

	always_comb begin
		top      = '0;
		ctl.dir  = '0;
		ctl.side = 1'b0;
		ctl.last = last;
		for (int i = 0; i < LANES; i++) begin
			if (win[i]) begin
				top      = resp[i];
				ctl.dir  = DIR_W'(i);
				ctl.side = side[i];
			end
		end
	end

endmodule

/* hw/rtl/ddsc_accum.sv */
// Running best over the scales of a pixel and the registered output of the finished code.
module ddsc_accum #(
	parameter int RESPONSE_WIDTH = ddsc_pkg::DEF_RESPONSE_WIDTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             valid,
	input  logic signed [RESPONSE_WIDTH-1:0] top,
	input  ddsc_pkg::scale_ctl_t             ctl,
	output logic                             go,
	ddsc_code_if.source                      code
);
	import ddsc_pkg::*;

	logic                             have_best_q;
	logic signed [RESPONSE_WIDTH-1:0] best_resp_q;
	logic [DIR_W-1:0]                 best_dir_q;
	logic                             best_side_q;
	logic                             out_valid_q;
	logic signed [RESPONSE_WIDTH-1:0] out_resp_q;
	logic [DIR_W-1:0]                 out_dir_q;
	logic                             out_side_q;

	logic                             upd;
	logic signed [RESPONSE_WIDTH-1:0] nb_resp;
	logic [DIR_W-1:0]                 nb_dir;
	logic                             nb_side;

	always_comb begin
		upd     = !have_best_q || (top > best_resp_q);
		nb_resp = upd ? top : best_resp_q;
		nb_dir  = upd ? ctl.dir : best_dir_q;
		nb_side = upd ? ctl.side : best_side_q;
		go      = valid && (!ctl.last || !out_valid_q || code.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_best_q <= 1'b0;
			best_resp_q <= '0;
			best_dir_q  <= '0;
			best_side_q <= 1'b0;
		end else if (go) begin
			if (ctl.last) begin
				have_best_q <= 1'b0;
				best_resp_q <= '0;
				best_dir_q  <= '0;
				best_side_q <= 1'b0;
			end else begin
				have_best_q <= 1'b1;
				best_resp_q <= nb_resp;
				best_dir_q  <= nb_dir;
				best_side_q <= nb_side;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && ctl.last) begin
			out_valid_q <= 1'b1;
		end else if (code.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && ctl.last) begin
			out_resp_q <= nb_resp;
			out_dir_q  <= nb_dir;
			out_side_q <= nb_side;
		end
	end

	assign code.valid              = out_valid_q;
	assign code.max_response       = out_resp_q;
	assign code.dominant_direction = out_dir_q;
	assign code.side_bit           = out_side_q;

	// A last scale always leaves the running best empty.
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(go && ctl.last) |=> !have_best_q)
		else $error("running best not cleared after last scale");

	// An intermediate scale always leaves a running best behind.
	a_best_after_scale: assert property (@(posedge clk) disable iff (!arst_n)
		(go && !ctl.last) |=> have_best_q)
		else $error("running best missing after intermediate scale");

	// A new code appears only from a last scale.
	a_code_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(go && ctl.last))
		else $error("code produced without a last scale");

	// A last scale is never taken while an unread code would be overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(go && ctl.last && out_valid_q) |-> code.ready)
		else $error("pending code overwritten");

endmodule
